// ===== rtl/rhsd_pkg.sv =====
package rhsd_pkg;

    localparam int COORD_BITS_DEF = 14;
    localparam int TRIG_BITS      = 18;
    localparam int Q16_SHIFT      = 16;
    localparam int LEN_BITS       = 30;
    localparam int OUT_TDATA_W    = ((LEN_BITS + 7) / 8) * 8;

    localparam logic [TRIG_BITS-1:0] TRIG_THRESHOLD = TRIG_BITS'(1024);
    localparam logic [LEN_BITS-1:0]  LEN_MAX        = {LEN_BITS{1'b1}};

    localparam logic SIDE_HORIZ = 1'b0;
    localparam logic SIDE_VERT  = 1'b1;

    function automatic logic [TRIG_BITS-1:0] trig_mag(input logic [TRIG_BITS-1:0] v);
        logic [TRIG_BITS-1:0] r;
        r = v[TRIG_BITS-1] ? (~v + TRIG_BITS'(1)) : v;
        return r;
    endfunction

endpackage

// ===== rtl/rhsd_div.sv =====
module rhsd_div
    import rhsd_pkg::*;
#(
    parameter int QUO_BITS = COORD_BITS_DEF + Q16_SHIFT,
    parameter int DEN_BITS = TRIG_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [QUO_BITS-1:0] in_num,
    input  logic [DEN_BITS-1:0] in_den,
    input  logic                in_side,
    output logic                out_valid,
    output logic [QUO_BITS-1:0] out_quo,
    output logic                out_den_zero,
    output logic                out_side
);

    logic                valid_reg [QUO_BITS];
    logic [DEN_BITS-1:0] rem_reg   [QUO_BITS];
    logic [QUO_BITS-1:0] quo_reg   [QUO_BITS];
    logic [QUO_BITS-1:0] num_reg   [QUO_BITS];
    logic [DEN_BITS-1:0] den_reg   [QUO_BITS];
    logic                side_reg  [QUO_BITS];

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        logic                valid_in;
        logic [DEN_BITS-1:0] rem_in;
        logic [QUO_BITS-1:0] quo_in;
        logic [QUO_BITS-1:0] num_in;
        logic [DEN_BITS-1:0] den_in;
        logic                side_in;
        logic [DEN_BITS:0]   trial;
        logic                ge;
        logic [DEN_BITS-1:0] rem_next;
        logic [QUO_BITS-1:0] quo_next;

        if (k == 0) begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = '0;
            assign quo_in   = '0;
            assign num_in   = in_num;
            assign den_in   = in_den;
            assign side_in  = in_side;
        end else begin : g_next
            assign valid_in = valid_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign quo_in   = quo_reg[k-1];
            assign num_in   = num_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign side_in  = side_reg[k-1];
        end

        always_comb begin
            trial    = {rem_in, num_in[QUO_BITS-1-k]};
            ge       = (trial >= {1'b0, den_in});
            rem_next = ge ? DEN_BITS'(trial - {1'b0, den_in}) : trial[DEN_BITS-1:0];
            quo_next = quo_in;
            quo_next[QUO_BITS-1-k] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                num_reg[k]  <= num_in;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid    = valid_reg[QUO_BITS-1];
    assign out_quo      = quo_reg[QUO_BITS-1];
    assign out_den_zero = (den_reg[QUO_BITS-1] == '0);
    assign out_side     = side_reg[QUO_BITS-1];

endmodule

// ===== rtl/ray_hit_select_distance.sv =====
// Channel  Dir  Beat contents
// s_axis   in   tdata: start_x, start_y, horiz_hit_valid, horiz_hit_x, horiz_hit_y,
//               vert_hit_valid, vert_hit_x, vert_hit_y, ray_sine, ray_cosine
// m_axis   out  tdata: ray_length; tuser: wall_side
//
// One beat per cycle in and out while m_axis does not stall. The pipeline is:
// four stages of distance and selection, one divider stage per quotient bit,
// one output register. aresetn clears only the valid bits. A stall on m_axis
// freezes every stage at once; s_axis_tready follows the output register.
module ray_hit_select_distance
    import rhsd_pkg::*;
#(
    parameter int  COORD_BITS = COORD_BITS_DEF,
    localparam int IN_BITS    = 6 * COORD_BITS + 2 + 2 * TRIG_BITS,
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_x, start_y, horiz_hit_valid, horiz_hit_x, horiz_hit_y,
    // vert_hit_valid, vert_hit_x, vert_hit_y, ray_sine, ray_cosine, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // ray_length, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // wall_side
    output logic                   m_axis_tuser
);

    localparam int SQ_BITS    = 2 * COORD_BITS;
    localparam int SUM_BITS   = SQ_BITS + 1;
    localparam int QUO_BITS   = COORD_BITS + Q16_SHIFT;
    localparam int CMP_BITS   = (QUO_BITS > LEN_BITS) ? QUO_BITS : LEN_BITS;

    localparam int SX_LO = 0;
    localparam int SY_LO = SX_LO + COORD_BITS;
    localparam int HV_LO = SY_LO + COORD_BITS;
    localparam int HX_LO = HV_LO + 1;
    localparam int HY_LO = HX_LO + COORD_BITS;
    localparam int VV_LO = HY_LO + COORD_BITS;
    localparam int VX_LO = VV_LO + 1;
    localparam int VY_LO = VX_LO + COORD_BITS;
    localparam int SN_LO = VY_LO + COORD_BITS;
    localparam int CS_LO = SN_LO + TRIG_BITS;

    logic ce;

    logic                  sx, sy;
    logic [COORD_BITS-1:0] in_sx, in_sy, in_hx, in_hy, in_vx, in_vy;
    logic [TRIG_BITS-1:0]  in_sin, in_cos;

    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;

    assign in_sx  = s_axis_tdata[SX_LO +: COORD_BITS];
    assign in_sy  = s_axis_tdata[SY_LO +: COORD_BITS];
    assign in_hx  = s_axis_tdata[HX_LO +: COORD_BITS];
    assign in_hy  = s_axis_tdata[HY_LO +: COORD_BITS];
    assign in_vx  = s_axis_tdata[VX_LO +: COORD_BITS];
    assign in_vy  = s_axis_tdata[VY_LO +: COORD_BITS];
    assign in_sin = s_axis_tdata[SN_LO +: TRIG_BITS];
    assign in_cos = s_axis_tdata[CS_LO +: TRIG_BITS];
    assign sx     = s_axis_tdata[HV_LO];
    assign sy     = s_axis_tdata[VV_LO];

    // stage 1: deltas and trig magnitudes
    logic                  v1_reg;
    logic                  hval1_reg, vval1_reg;
    logic [COORD_BITS-1:0] hdx1_reg, hdy1_reg, vdx1_reg, vdy1_reg;
    logic [TRIG_BITS-1:0]  smag1_reg, cmag1_reg;

    function automatic logic [COORD_BITS-1:0] absdiff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
        logic [COORD_BITS-1:0] r;
        r = (a >= b) ? (a - b) : (b - a);
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (ce) begin
            hval1_reg <= sx;
            vval1_reg <= sy;
            hdx1_reg  <= absdiff(in_hx, in_sx);
            hdy1_reg  <= absdiff(in_hy, in_sy);
            vdx1_reg  <= absdiff(in_vx, in_sx);
            vdy1_reg  <= absdiff(in_vy, in_sy);
            smag1_reg <= trig_mag(in_sin);
            cmag1_reg <= trig_mag(in_cos);
        end
    end

    // stage 2: squares
    logic                  v2_reg;
    logic                  hval2_reg, vval2_reg;
    logic [COORD_BITS-1:0] hdx2_reg, hdy2_reg, vdx2_reg, vdy2_reg;
    logic [TRIG_BITS-1:0]  smag2_reg, cmag2_reg;
    logic [SQ_BITS-1:0]    hsx2_reg, hsy2_reg, vsx2_reg, vsy2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            hval2_reg <= hval1_reg;
            vval2_reg <= vval1_reg;
            hdx2_reg  <= hdx1_reg;
            hdy2_reg  <= hdy1_reg;
            vdx2_reg  <= vdx1_reg;
            vdy2_reg  <= vdy1_reg;
            smag2_reg <= smag1_reg;
            cmag2_reg <= cmag1_reg;
            hsx2_reg  <= SQ_BITS'(hdx1_reg) * SQ_BITS'(hdx1_reg);
            hsy2_reg  <= SQ_BITS'(hdy1_reg) * SQ_BITS'(hdy1_reg);
            vsx2_reg  <= SQ_BITS'(vdx1_reg) * SQ_BITS'(vdx1_reg);
            vsy2_reg  <= SQ_BITS'(vdy1_reg) * SQ_BITS'(vdy1_reg);
        end
    end

    // stage 3: squared distances
    logic                  v3_reg;
    logic                  hval3_reg, vval3_reg;
    logic [COORD_BITS-1:0] hdx3_reg, hdy3_reg, vdx3_reg, vdy3_reg;
    logic [TRIG_BITS-1:0]  smag3_reg, cmag3_reg;
    logic [SUM_BITS-1:0]   hd3_reg, vd3_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            hval3_reg <= hval2_reg;
            vval3_reg <= vval2_reg;
            hdx3_reg  <= hdx2_reg;
            hdy3_reg  <= hdy2_reg;
            vdx3_reg  <= vdx2_reg;
            vdy3_reg  <= vdy2_reg;
            smag3_reg <= smag2_reg;
            cmag3_reg <= cmag2_reg;
            hd3_reg   <= SUM_BITS'(hsx2_reg) + SUM_BITS'(hsy2_reg);
            vd3_reg   <= SUM_BITS'(vsx2_reg) + SUM_BITS'(vsy2_reg);
        end
    end

    // stage 4: pick side, delta and divisor
    logic                  v4_reg;
    logic                  side4_reg;
    logic [QUO_BITS-1:0]   num4_reg;
    logic [TRIG_BITS-1:0]  den4_reg;
    logic                  pick_vert;
    logic [COORD_BITS-1:0] delta_sel;
    logic [TRIG_BITS-1:0]  den_sel;

    always_comb begin
        priority if (!vval3_reg) begin
            pick_vert = SIDE_HORIZ;
        end else if (!hval3_reg) begin
            pick_vert = SIDE_VERT;
        end else begin
            pick_vert = (hd3_reg > vd3_reg);
        end

        if (pick_vert) begin
            if (smag3_reg > TRIG_THRESHOLD) begin
                delta_sel = vdx3_reg;
                den_sel   = smag3_reg;
            end else begin
                delta_sel = vdy3_reg;
                den_sel   = cmag3_reg;
            end
        end else begin
            if (cmag3_reg > TRIG_THRESHOLD) begin
                delta_sel = hdy3_reg;
                den_sel   = cmag3_reg;
            end else begin
                delta_sel = hdx3_reg;
                den_sel   = smag3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side4_reg <= pick_vert;
            num4_reg  <= {delta_sel, {Q16_SHIFT{1'b0}}};
            den4_reg  <= den_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // divider
    logic                div_valid;
    logic [QUO_BITS-1:0] div_quo;
    logic                div_zero;
    logic                div_side;

    rhsd_div #(
        .QUO_BITS (QUO_BITS),
        .DEN_BITS (TRIG_BITS)
    ) u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (ce),
        .in_valid     (v4_reg),
        .in_num       (num4_reg),
        .in_den       (den4_reg),
        .in_side      (side4_reg),
        .out_valid    (div_valid),
        .out_quo      (div_quo),
        .out_den_zero (div_zero),
        .out_side     (div_side)
    );

    // output register with saturation
    logic                m_valid_reg;
    logic [LEN_BITS-1:0] len_reg;
    logic                side_reg;
    logic [LEN_BITS-1:0] len_next;
    logic [CMP_BITS-1:0] quo_ext;

    always_comb begin
        quo_ext = CMP_BITS'(div_quo);
        if (div_zero || (quo_ext > CMP_BITS'(LEN_MAX))) begin
            len_next = LEN_MAX;
        end else begin
            len_next = quo_ext[LEN_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            len_reg  <= len_next;
            side_reg <= div_side;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(len_reg);
    assign m_axis_tuser  = side_reg;

endmodule

// ===== tb/ray_hit_select_distance_tb.sv =====
`timescale 1ns / 100ps

module ray_hit_select_distance_tb;
    import rhsd_pkg::*;

    localparam int CRD       = 14;
    localparam int RAY_W     = 128;
    localparam int N_RANDOM  = 1950;
    localparam int CYC_LIMIT = 400000;
    localparam int DRAIN     = 60;

    // beat layout, lowest field last
    typedef struct packed {
        logic [5:0]           fill;
        logic signed [17:0]   ray_cosine;
        logic signed [17:0]   ray_sine;
        logic [CRD-1:0]       vert_hit_y;
        logic [CRD-1:0]       vert_hit_x;
        logic                 vert_hit_valid;
        logic [CRD-1:0]       horiz_hit_y;
        logic [CRD-1:0]       horiz_hit_x;
        logic                 horiz_hit_valid;
        logic [CRD-1:0]       start_y;
        logic [CRD-1:0]       start_x;
    } ray_t;

    typedef struct {
        logic                side;
        logic [LEN_BITS-1:0] len;
    } hit_t;

    class hit_scoreboard;
        hit_t pending[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function longint scaled_len(longint delta, longint div);
            longint q;
            if (div == 0)
                return longint'(LEN_MAX);
            q = (delta * 65536) / div;
            return (q > longint'(LEN_MAX)) ? longint'(LEN_MAX) : q;
        endfunction

        function hit_t expected_hit(ray_t r);
            longint sx, sy, hdx, hdy, vdx, vdy, sn, cs;
            hit_t   h;
            sx  = r.start_x;
            sy  = r.start_y;
            hdx = longint'(r.horiz_hit_x) - sx;
            hdy = longint'(r.horiz_hit_y) - sy;
            vdx = longint'(r.vert_hit_x) - sx;
            vdy = longint'(r.vert_hit_y) - sy;
            if (hdx < 0) hdx = -hdx;
            if (hdy < 0) hdy = -hdy;
            if (vdx < 0) vdx = -vdx;
            if (vdy < 0) vdy = -vdy;
            sn = longint'($signed(r.ray_sine));
            cs = longint'($signed(r.ray_cosine));
            if (sn < 0) sn = -sn;
            if (cs < 0) cs = -cs;
            if (!r.vert_hit_valid)
                h.side = SIDE_HORIZ;
            else if (!r.horiz_hit_valid)
                h.side = SIDE_VERT;
            else if (hdx * hdx + hdy * hdy > vdx * vdx + vdy * vdy)
                h.side = SIDE_VERT;
            else
                h.side = SIDE_HORIZ;
            if (h.side == SIDE_VERT)
                h.len = LEN_BITS'((sn > 1024) ? scaled_len(vdx, sn) : scaled_len(vdy, cs));
            else
                h.len = LEN_BITS'((cs > 1024) ? scaled_len(hdy, cs) : scaled_len(hdx, sn));
            return h;
        endfunction

        function void note_ray(ray_t r);
            pending.push_back(expected_hit(r));
        endfunction

        function void check_result(logic side, logic [LEN_BITS-1:0] len);
            hit_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: side %0d len %0d", side, len);
                return;
            end
            want = pending.pop_front();
            if (side !== want.side) begin
                errors++;
                if (errors <= 10)
                    $display("wall_side: expected %0d got %0d", want.side, side);
            end
            if (len !== want.len) begin
                errors++;
                if (errors <= 10)
                    $display("ray_length: expected %0d got %0d", want.len, len);
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [RAY_W-1:0]       s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    hit_scoreboard sb;
    int            cycles = 0;

    ray_hit_select_distance dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("ray_hit_select_distance_tb: errors");
            $finish;
        end
    end

    // beat monitor
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            sb.note_ray(ray_t'(s_axis_tdata));
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata[LEN_BITS-1:0]);
    end

    // receiver stall pattern, mode taken from bits 9:8 of the cycle counter
    always @(negedge aclk) begin
        case (cycles[9:8])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (cycles[2:0] != 3'd5) && (cycles[4:3] != 2'd2);
        endcase
    end

    function automatic ray_t mk_ray(int sx, int sy, bit hv, int hx, int hy,
                                    bit vv, int vx, int vy, int sn, int cs);
        ray_t r;
        r                 = '0;
        r.start_x         = CRD'(sx);
        r.start_y         = CRD'(sy);
        r.horiz_hit_valid = hv;
        r.horiz_hit_x     = CRD'(hx);
        r.horiz_hit_y     = CRD'(hy);
        r.vert_hit_valid  = vv;
        r.vert_hit_x      = CRD'(vx);
        r.vert_hit_y      = CRD'(vy);
        r.ray_sine        = 18'(sn);
        r.ray_cosine      = 18'(cs);
        return r;
    endfunction

    function automatic int rand_trig();
        case ($urandom_range(0, 5))
            0: return int'($signed(18'($urandom)));
            1: return int'($urandom_range(0, 2200)) - 1100;
            2: begin
                case ($urandom_range(0, 6))
                    0: return 1024;
                    1: return -1024;
                    2: return 1025;
                    3: return -1025;
                    4: return 0;
                    5: return 65536;
                    default: return -65536;
                endcase
            end
            default: return int'($urandom_range(0, 131072)) - 65536;
        endcase
    endfunction

    function automatic int near_coord(int c);
        int v;
        v = c + int'($urandom_range(0, 256)) - 128;
        if (v < 0) v = 0;
        if (v > 16383) v = 16383;
        return v;
    endfunction

    function automatic ray_t rand_ray();
        ray_t r;
        int   sx, sy;
        if ($urandom_range(0, 3) == 0) begin
            r = ray_t'({$urandom, $urandom, $urandom, $urandom});
            r.fill = '0;
            return r;
        end
        sx = $urandom_range(0, 16383);
        sy = $urandom_range(0, 16383);
        r = mk_ray(sx, sy, $urandom_range(0, 7) != 0, near_coord(sx), near_coord(sy),
                   $urandom_range(0, 7) != 0, near_coord(sx), near_coord(sy),
                   rand_trig(), rand_trig());
        return r;
    endfunction

    task automatic send_ray(input ray_t r);
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic idle_in(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic send_burst(input ray_t r, inout int burst_left);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
                idle_in(gap);
            burst_left = $urandom_range(1, 24);
        end
        send_ray(r);
        burst_left--;
    endtask

    initial begin
        ray_t directed[$];
        int   burst_left;
        sb            = new();
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        burst_left    = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // both invalid, zero divisor
        directed.push_back(mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk_ray(100, 100, 1, 300, 164, 0, 7, 9, 30000, 40000));
        directed.push_back(mk_ray(100, 100, 0, 5, 6, 1, 250, 400, 45000, -30000));
        directed.push_back(mk_ray(500, 500, 1, 520, 510, 1, 700, 900, 20000, 60000));
        directed.push_back(mk_ray(500, 500, 1, 800, 900, 1, 510, 505, -20000, 60000));
        // equal distances go horizontal
        directed.push_back(mk_ray(100, 100, 1, 110, 100, 1, 100, 110, 40000, 40000));
        // trig right at and just past the threshold
        directed.push_back(mk_ray(200, 200, 1, 260, 230, 0, 0, 0, 60000, 1024));
        directed.push_back(mk_ray(200, 200, 1, 260, 230, 0, 0, 0, 60000, -1025));
        directed.push_back(mk_ray(200, 200, 0, 0, 0, 1, 230, 260, 1024, 60000));
        directed.push_back(mk_ray(200, 200, 0, 0, 0, 1, 230, 260, -1025, 60000));
        directed.push_back(mk_ray(200, 200, 0, 0, 0, 1, 230, 260, 0, 0));
        // long lengths and extreme trig values
        directed.push_back(mk_ray(0, 0, 1, 16383, 16383, 0, 0, 0, 1, 1));
        directed.push_back(mk_ray(0, 0, 1, 16383, 16383, 0, 0, 0, 2, 2));
        directed.push_back(mk_ray(0, 0, 1, 9, 16383, 0, 0, 0, 0, -131072));
        directed.push_back(mk_ray(0, 0, 1, 9, 16383, 0, 0, 0, 0, 131071));
        directed.push_back(mk_ray(4000, 4000, 0, 0, 0, 1, 3000, 5000, -131072, 5));
        directed.push_back(mk_ray(300, 300, 1, 400, 200, 1, 250, 350, 65536, -65536));
        // hit on the start point
        directed.push_back(mk_ray(777, 888, 1, 777, 888, 1, 777, 888, 30000, 30000));
        directed.push_back(mk_ray(0, 0, 1, 16383, 16383, 1, 16383, 16382, 46341, 46341));
        directed.push_back(mk_ray(16383, 16383, 1, 0, 0, 1, 0, 1, -46341, -46341));
        directed.push_back(mk_ray(16383, 0, 1, 0, 16383, 1, 16383, 0, -65536, 65536));

        foreach (directed[i])
            send_burst(directed[i], burst_left);
        repeat (N_RANDOM)
            send_burst(rand_ray(), burst_left);
        idle_in(1);

        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        if (sb.errors == 0)
            $display("ray_hit_select_distance_tb: clean");
        else
            $display("ray_hit_select_distance_tb: errors");
        $finish;
    end

endmodule
